[rtl/lpb_pkg.sv]
// Shared types and codes for the long-press power button controller.
// No dependencies; every other file in rtl/ imports this package.
package lpb_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SAMPLE = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] HOLD_LIMIT_RST     = 16'd3000;
  localparam logic [CFG_W-1:0] BLINK_PERIOD_RST   = 16'd500;
  localparam logic [CFG_W-1:0] BLINK_ON_RST       = 16'd250;
  localparam logic [CFG_W-1:0] RELEASE_SAMPLE_RST = 16'd100;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_DISCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LED_NONE     = 2'd0,
    LED_OFF      = 2'd1,
    LED_DEFAULT  = 2'd2,
    LED_SHUTDOWN = 2'd3
  } led_t;

  typedef struct packed {
    logic [CFG_W-1:0] hold_limit_ms;
    logic [CFG_W-1:0] led_period_ms;
    logic [CFG_W-1:0] led_on_ms;
    logic [CFG_W-1:0] release_sample_ms;
  } lpb_cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] led_cmd;
    logic       drive_low;
    logic       sample_strobe;
  } lpb_result_t;

endpackage

[rtl/lpb_ifs.sv]
// Handshake channels of the long-press power button controller.
// Depends on lpb_pkg for the configuration field widths.
interface lpb_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface lpb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] led_cmd;
  logic       drive_low;
  logic       sample_strobe;
  modport source (output valid, output mode, output led_cmd, output drive_low,
                  output sample_strobe, input ready);
  modport sink (input valid, input mode, input led_cmd, input drive_low,
                input sample_strobe, output ready);
endinterface

interface lpb_cfg_if
  import lpb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lpb_step.sv]
// Next-state and result logic for one millisecond tick of the controller.
// Purely combinational; depends on lpb_pkg for codes and structs.
module lpb_step
  import lpb_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  lpb_cfg_t              cfg,
  input  logic                  level,
  input  mode_t                 mode,
  input  logic [COUNT_BITS-1:0] held,
  input  logic [COUNT_BITS-1:0] phase,
  input  logic [COUNT_BITS-1:0] timer,
  input  logic                  begun,
  output mode_t                 mode_nxt,
  output logic [COUNT_BITS-1:0] held_nxt,
  output logic [COUNT_BITS-1:0] phase_nxt,
  output logic [COUNT_BITS-1:0] timer_nxt,
  output logic                  begun_nxt,
  output lpb_result_t           result
);

  localparam int CW = COUNT_BITS;
  // Compare widths wide enough for both counters and 16-bit registers.
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;
  localparam int PW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [CW-1:0]    held_inc;
  logic [CW:0]      phase_inc;
  logic [CW-1:0]    phase_wrap;
  logic [CFG_W-1:0] interval_raw;
  logic [CW-1:0]    interval;
  logic [CW-1:0]    timer_dec;
  led_t             led;
  logic             strobe;

  // Counter arithmetic shared by the mode branches.
  always_comb begin
    held_inc = (held == CNT_MAX) ? held : held + 1'b1;
    phase_inc = (CW + 1)'(phase) + 1'b1;
    if (PW'(phase_inc) >= PW'(cfg.led_period_ms)) begin
      phase_wrap = '0;
    end else if (phase_inc[CW]) begin
      phase_wrap = CNT_MAX;
    end else begin
      phase_wrap = phase_inc[CW-1:0];
    end
    // A zero interval acts as one; large intervals clip to the counter range.
    interval_raw = (cfg.release_sample_ms == '0) ? CFG_W'(1) : cfg.release_sample_ms;
    if (XW'(interval_raw) > XW'(CNT_MAX)) begin
      interval = CNT_MAX;
    end else begin
      interval = CW'(interval_raw);
    end
    timer_dec = (timer != '0) ? timer - 1'b1 : '0;
  end

  // Mode transitions for one tick.
  always_comb begin
    mode_nxt  = mode;
    held_nxt  = held;
    phase_nxt = phase;
    timer_nxt = timer;
    begun_nxt = begun;
    led       = LED_NONE;
    strobe    = 1'b0;
    unique case (mode)
      MODE_DISCH: begin
        if (!begun) begin
          begun_nxt = 1'b1;
          held_nxt  = '0;
          led       = LED_OFF;
          timer_nxt = interval;
        end else begin
          timer_nxt = timer_dec;
          if (timer_dec == '0) begin
            strobe = 1'b1;
            if (level) begin
              mode_nxt  = MODE_IDLE;
              begun_nxt = 1'b0;
              held_nxt  = '0;
              led       = LED_DEFAULT;
            end else begin
              timer_nxt = interval;
            end
          end
        end
      end
      MODE_HOLD: begin
        if (level) begin
          mode_nxt = MODE_IDLE;
          held_nxt = '0;
          led      = LED_DEFAULT;
        end else begin
          held_nxt  = held_inc;
          phase_nxt = phase_wrap;
          led = (XW'(phase_wrap) < XW'(cfg.led_on_ms)) ? LED_SHUTDOWN : LED_DEFAULT;
          if (XW'(held_inc) >= XW'(cfg.hold_limit_ms)) begin
            mode_nxt  = MODE_DISCH;
            begun_nxt = 1'b0;
          end
        end
      end
      default: begin
        // Idle, and the unused code, which behaves as idle.
        if (!level) begin
          mode_nxt  = MODE_HOLD;
          held_nxt  = '0;
          phase_nxt = '0;
        end
      end
    endcase
  end

  always_comb begin
    result.mode          = mode_nxt;
    result.led_cmd       = led;
    result.drive_low     = (mode_nxt == MODE_DISCH) && begun_nxt;
    result.sample_strobe = strobe;
  end

endmodule

[rtl/long_press_power_button_fsm.sv]
// Long-press power button controller, one input beat per millisecond tick.
// Each accepted input beat's result is registered in the output register.
// Throughput: one beat per cycle while the output is not stalled; input ready
// follows the output register (free, or being taken in the same cycle).
// Reset (rst_n, synchronous, active low): idle mode, counters zero, output
// empty, configuration registers at 3000 / 500 / 250 / 100 ms.
module long_press_power_button_fsm
  import lpb_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  lpb_in_if.sink   in_bus,
  lpb_out_if.source out_bus,
  lpb_cfg_if.sink  cfg_bus
);

  lpb_cfg_t              cfg_r;
  mode_t                 mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] held_r, held_nxt;
  logic [COUNT_BITS-1:0] phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] timer_r, timer_nxt;
  logic                  begun_r, begun_nxt;
  lpb_result_t           result_r, result_nxt;
  logic                  out_valid_r;
  logic                  in_fire;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;

  // Configuration register file; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_limit_ms     <= HOLD_LIMIT_RST;
      cfg_r.led_period_ms     <= BLINK_PERIOD_RST;
      cfg_r.led_on_ms         <= BLINK_ON_RST;
      cfg_r.release_sample_ms <= RELEASE_SAMPLE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_HOLD_LIMIT:     cfg_r.hold_limit_ms     <= cfg_bus.data;
        REG_BLINK_PERIOD:   cfg_r.led_period_ms     <= cfg_bus.data;
        REG_BLINK_ON:       cfg_r.led_on_ms         <= cfg_bus.data;
        REG_RELEASE_SAMPLE: cfg_r.release_sample_ms <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  lpb_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .cfg       (cfg_r),
    .level     (in_bus.button_level),
    .mode      (mode_r),
    .held      (held_r),
    .phase     (phase_r),
    .timer     (timer_r),
    .begun     (begun_r),
    .mode_nxt  (mode_nxt),
    .held_nxt  (held_nxt),
    .phase_nxt (phase_nxt),
    .timer_nxt (timer_nxt),
    .begun_nxt (begun_nxt),
    .result    (result_nxt)
  );

  // State and output register advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      held_r      <= '0;
      phase_r     <= '0;
      timer_r     <= '0;
      begun_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        held_r      <= held_nxt;
        phase_r     <= phase_nxt;
        timer_r     <= timer_nxt;
        begun_r     <= begun_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.mode          = result_r.mode;
  assign out_bus.led_cmd       = result_r.led_cmd;
  assign out_bus.drive_low     = result_r.drive_low;
  assign out_bus.sample_strobe = result_r.sample_strobe;

`ifndef ASSERT_OFF
  // The discharge flag is only ever set while in discharged mode.
  a_begun_mode: assert property (@(posedge clk) disable iff (!rst_n)
    begun_r |-> (mode_r == MODE_DISCH))
    else $error("discharge flag set outside discharged mode");

  // A driven-low result reports discharged mode.
  a_drive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.drive_low) |-> (result_r.mode == MODE_DISCH))
    else $error("drive_low without discharged mode");

  // A sample tick never turns the LED off or shows the shutdown colour.
  a_strobe_led: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.sample_strobe) |->
      (result_r.led_cmd == LED_NONE || result_r.led_cmd == LED_DEFAULT))
    else $error("sample tick with unexpected LED command");

  // A stalled result beat stays in place until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(result_r)))
    else $error("stalled result beat changed");
`endif

endmodule
